// File: rtl/core/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types and constants of the range-sensor frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

    // Frame layout
    localparam int FRAME_LEN      = 16;
    localparam int IDX_W          = $clog2(FRAME_LEN);
    localparam logic [7:0] HDR_BYTE = 8'h57;
    localparam logic [IDX_W-1:0] IDX_FIRST_FIELD = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_LAST_FIELD  = IDX_W'(13);
    localparam logic [IDX_W-1:0] IDX_CHECKSUM    = IDX_W'(FRAME_LEN - 1);
    localparam int FIELD_BYTES    = 11;
    localparam int FIELD_W        = FIELD_BYTES * 8;

    // Widths of the derived values
    localparam int DIST_W   = 24;
    localparam int TILT_W   = 16;
    localparam int LIMIT_W  = 23;
    localparam int VEL_W    = DIST_W + 1;
    localparam int DVEL_W   = VEL_W + 1;
    localparam int ACC_W    = 30;
    localparam int PROD_W   = DIST_W + TILT_W;
    localparam int TILT_FRAC = 14;
    localparam int GDW_W    = PROD_W - TILT_FRAC;
    localparam int OUT_W    = 168;

    // Parser states
    typedef enum logic {
        ST_HUNT,
        ST_BODY
    } state_t;

    // Frame bytes 3..13, byte 3 in the lowest bits
    typedef struct packed {
        logic [15:0] strength;
        logic [7:0]  status;
        logic [23:0] range_mm;
        logic [31:0] stamp;
        logic [7:0]  id;
    } fields_t;

    // One good frame handed from the parser to the math side
    typedef struct packed {
        logic signed [TILT_W-1:0] tilt;
        fields_t                  fields;
    } rec_t;

endpackage

// File: rtl/core/tfp_front.sv
// ----------------------------------------------------------------------------
// tfp_front
// Byte-wise frame parser: header hunt, field capture and checksum check.
// ----------------------------------------------------------------------------
module tfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    input  logic signed [15:0]   tilt_cos,
    output logic                 push,
    input  logic                 push_ready,
    output tfp_pkg::rec_t        push_rec
);

    tfp_pkg::state_t                state_reg, state_next;
    logic [tfp_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [7:0]                     sum_reg, sum_next;
    logic [tfp_pkg::FIELD_W-1:0]    field_reg;
    logic                           accept;
    logic                           at_checksum;
    logic                           in_field;

    assign at_checksum = (state_reg == tfp_pkg::ST_BODY) && (idx_reg == tfp_pkg::IDX_CHECKSUM);
    assign in_field    = (idx_reg >= tfp_pkg::IDX_FIRST_FIELD) &&
                         (idx_reg <= tfp_pkg::IDX_LAST_FIELD);
    assign accept      = in_valid && in_ready;

    // Next state, index and running sum
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        unique case (state_reg)
            tfp_pkg::ST_HUNT:
            begin
                if (accept && (rx_byte == tfp_pkg::HDR_BYTE))
                begin
                    state_next = tfp_pkg::ST_BODY;
                    idx_next   = tfp_pkg::IDX_W'(1);
                    sum_next   = tfp_pkg::HDR_BYTE;
                end
            end
            tfp_pkg::ST_BODY:
            begin
                if (accept)
                begin
                    if (idx_reg == tfp_pkg::IDX_CHECKSUM)
                    begin
                        state_next = tfp_pkg::ST_HUNT;
                        idx_next   = '0;
                        sum_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + tfp_pkg::IDX_W'(1);
                        sum_next = sum_reg + rx_byte;
                    end
                end
            end
            default:
            begin
                state_next = tfp_pkg::ST_HUNT;
            end
        endcase
    end

    // Handshake and frame hand-off; stall only on a checksum byte with a full queue
    always_comb
    begin
        in_ready      = !(at_checksum && !push_ready);
        push          = accept && at_checksum && (rx_byte == sum_reg);
        push_rec.tilt = tilt_cos;
        push_rec.fields = tfp_pkg::fields_t'(field_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfp_pkg::ST_HUNT;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

    // Field capture: new byte enters at the top, byte 3 ends in the low bits
    always_ff @(posedge clk)
    begin
        if (accept && (state_reg == tfp_pkg::ST_BODY) && in_field)
        begin
            field_reg <= {rx_byte, field_reg[tfp_pkg::FIELD_W-1:8]};
        end
    end

`ifndef SYNTH
    // A frame hand-off always ends the frame
    a_push_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (state_reg == tfp_pkg::ST_HUNT && idx_reg == '0))
        else $error("frame hand-off did not return parser to hunt");
`endif

endmodule

// File: rtl/core/tfp_queue.sv
// ----------------------------------------------------------------------------
// tfp_queue
// Two-entry queue of good frames between the parser and the math pipeline.
// ----------------------------------------------------------------------------
module tfp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  tfp_pkg::rec_t   wr_rec,
    output logic            rd_valid,
    input  logic            rd_ready,
    output tfp_pkg::rec_t   rd_rec
);

    tfp_pkg::rec_t  mem [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_rec   = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

`ifndef SYNTH
    // Fill count agrees with the pointers
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue count and pointers disagree");
`endif

endmodule

// File: rtl/core/tfp_back.sv
// ----------------------------------------------------------------------------
// tfp_back
// Math pipeline: velocity, acceleration, tilt-corrected ground distance and
// health flag, ending in the output register.
// ----------------------------------------------------------------------------
module tfp_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tfp_pkg::LIMIT_W-1:0]     ground_limit,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  tfp_pkg::rec_t                   q_rec,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tfp_pkg::OUT_W-1:0]       out_data
);

    // Stage 1 registers
    logic                                   s1_valid_reg;
    tfp_pkg::fields_t                       s1_fields_reg;
    logic signed [tfp_pkg::PROD_W-1:0]      s1_prod_reg;
    logic signed [tfp_pkg::VEL_W-1:0]       s1_vel_reg;
    logic signed [tfp_pkg::DVEL_W-1:0]      s1_dvel_reg;
    // History of the previous good frame
    logic signed [tfp_pkg::DIST_W-1:0]      prev_dist_reg;
    logic signed [tfp_pkg::VEL_W-1:0]       prev_vel_reg;
    // Output register
    logic                                   out_valid_reg;
    logic [tfp_pkg::OUT_W-1:0]              out_data_reg;

    logic                                   s1_ready;
    logic                                   s2_ready;
    logic                                   pop;
    logic signed [tfp_pkg::DIST_W-1:0]      range_cur;
    logic signed [tfp_pkg::VEL_W-1:0]       vel;
    logic signed [tfp_pkg::DVEL_W-1:0]      dvel;
    logic signed [tfp_pkg::PROD_W-1:0]      prod;
    logic signed [tfp_pkg::GDW_W-1:0]       gd_wide;
    logic signed [tfp_pkg::DIST_W-1:0]      gd;
    logic signed [tfp_pkg::ACC_W-1:0]       dvel_ext;
    logic signed [tfp_pkg::ACC_W-1:0]       acc;
    logic                                   ok;

    assign s2_ready = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_ready  = s1_ready;
    assign pop      = q_valid && s1_ready;

    // Stage 1 math: differences and the tilt product
    always_comb
    begin
        range_cur = signed'(q_rec.fields.range_mm);
        vel  = tfp_pkg::VEL_W'(range_cur) - tfp_pkg::VEL_W'(prev_dist_reg);
        dvel = tfp_pkg::DVEL_W'(vel) - tfp_pkg::DVEL_W'(prev_vel_reg);
        prod = tfp_pkg::PROD_W'(range_cur) * tfp_pkg::PROD_W'(q_rec.tilt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            prev_dist_reg <= '0;
            prev_vel_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg  <= 1'b1;
                prev_dist_reg <= range_cur;
                prev_vel_reg  <= vel;
            end
            else if (s2_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_fields_reg <= q_rec.fields;
            s1_prod_reg   <= prod;
            s1_vel_reg    <= vel;
            s1_dvel_reg   <= dvel;
        end
    end

    // Stage 2 math: floor shift with saturation, times-ten, limit check
    always_comb
    begin
        gd_wide = tfp_pkg::GDW_W'(s1_prod_reg >>> tfp_pkg::TILT_FRAC);
        if ((gd_wide[tfp_pkg::GDW_W-1:tfp_pkg::DIST_W-1] == '0) ||
            (gd_wide[tfp_pkg::GDW_W-1:tfp_pkg::DIST_W-1] == '1))
        begin
            gd = gd_wide[tfp_pkg::DIST_W-1:0];
        end
        else if (gd_wide[tfp_pkg::GDW_W-1])
        begin
            gd = {1'b1, {(tfp_pkg::DIST_W-1){1'b0}}};
        end
        else
        begin
            gd = {1'b0, {(tfp_pkg::DIST_W-1){1'b1}}};
        end
        dvel_ext = tfp_pkg::ACC_W'(s1_dvel_reg);
        acc      = (dvel_ext <<< 3) + (dvel_ext <<< 1);
        ok       = !gd[tfp_pkg::DIST_W-1] && (gd != '0) &&
                   (gd[tfp_pkg::LIMIT_W-1:0] <= ground_limit);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            out_data_reg <= {ok, gd, acc, s1_vel_reg, s1_fields_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    // A stalled stage 1 keeps its product for the output stage
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_prod_reg)))
        else $error("stage 1 lost data under stall");

    // History advances only with a frame entering the pipeline
    a_hist_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> ($stable(prev_dist_reg) && $stable(prev_vel_reg)))
        else $error("history changed without a frame");
`endif

endmodule

// File: rtl/core/tof_frame_parser.sv
// ----------------------------------------------------------------------------
// tof_frame_parser
// Range-sensor frame parser with motion and tilt-corrected ground distance.
// ----------------------------------------------------------------------------
// Input stream: one transaction per byte of the sensor link, carrying the
// byte and the current tilt cosine (Q2.14). A 16-byte frame starts with 0x57
// and closes with a mod-256 sum of the bytes before it. One byte is taken
// every cycle; the input stalls only when a checksum byte, good or bad,
// finds the two-entry frame queue full.
// Output stream: one transaction per good frame with the sensor fields,
// velocity, acceleration, ground distance and health flag. m_axis_tvalid
// rises once the frame's checksum byte has passed the queue write, the math
// stage and the output register. A stalled receiver holds the output register;
// the math stage and the queue absorb up to three more frames before input
// stalls.
// ground_limit_we/ground_limit_wdata write the ground distance limit (reset 4500 mm);
// the user must write it only while the block is idle; the block does not enforce it.
// Reset clears the parser to header hunt, empties the pipeline and zeroes
// the previous distance and velocity.
// ----------------------------------------------------------------------------
module tof_frame_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ground_limit_we,
    input  logic [22:0]                 ground_limit_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] rx_byte, [23:8] tilt_cos
    input  logic [23:0]                 s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] sensor_id, [39:8] sensor_time, [63:40] distance_mm,
    // [71:64] range_status, [87:72] echo_level, [112:88] velocity_cm_s,
    // [142:113] accel_cm_s2, [166:143] ground_distance_mm, [167] ground_ok
    output logic [167:0]                m_axis_tdata
);

    logic [tfp_pkg::LIMIT_W-1:0]    limit_reg;
    logic                           f_push;
    logic                           f_push_ready;
    tfp_pkg::rec_t                  f_rec;
    logic                           q_valid;
    logic                           q_ready;
    tfp_pkg::rec_t                  q_rec;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tfp_pkg::LIMIT_W'(4500);
        end
        else if (ground_limit_we)
        begin
            limit_reg <= ground_limit_wdata;
        end
    end

    tfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .rx_byte    (s_axis_tdata[7:0]),
        .tilt_cos   (signed'(s_axis_tdata[23:8])),
        .push       (f_push),
        .push_ready (f_push_ready),
        .push_rec   (f_rec)
    );

    tfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_push),
        .wr_ready (f_push_ready),
        .wr_rec   (f_rec),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_rec   (q_rec)
    );

    tfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ground_limit (limit_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_rec        (q_rec),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata)
    );

endmodule
